// File: rtl/core/sed_pkg.sv
// Types and constants shared by the string escape decoder.
// No dependencies; imported by string_escape_decoder.
package sed_pkg;

  // Decoder mode, one-hot
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_OCTAL  = 3'b100
  } mode_t;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [4:0] OCT_PREFIX   = 5'b00110;  // '0'..'7' share these upper bits

  localparam logic [7:0] OVERFLOW_BYTE = 8'h40;
  localparam logic [1:0] OCT_LAST_CNT  = 2'd2;     // digits held before the third arrives

  // One decoded word
  typedef struct packed {
    logic [7:0] byte_out;
    logic       eos;
    logic [1:0] status;
  } res_t;

  // Build the word for a finished octal escape
  function automatic res_t oct_word(input logic [8:0] val, input logic eos);
    res_t r;
    r.eos = eos;
    if (val[8]) begin
      r.byte_out = OVERFLOW_BYTE;
      r.status   = ST_OVERFLOW;
    end else begin
      r.byte_out = val[7:0];
      r.status   = ST_OK;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/string_escape_decoder.sv
// String literal escape decoder: one raw character in, zero to two decoded words out.
// Depends on sed_pkg (mode type, status codes, character constants).
//
//  channel | signals                                    | dir | word
//  --------+--------------------------------------------+-----+------------------------------
//  in      | in_valid, in_stall, ch, is_last            | in  | one raw character + end mark
//  out     | out_valid, out_stall, byte_out,            | out | one decoded byte, end mark,
//          | end_of_string, status                      |     | status
//
// Each character is decoded in the cycle it is accepted and its words land in a
// three-entry result queue; the first word is visible the next cycle.
// One character per cycle is sustained while out_stall is low; a character that flushes a
// pending octal escape and yields a second word holds the input until the queue drain
// of one word per cycle catches up (input stalls while two or more words are queued).
// Reset (rst, synchronous) empties the queue and returns to normal mode.
// out_stall only holds the queue head; input keeps flowing until two words are queued.
module string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic       end_of_string,
  output logic [1:0] status
);
  import sed_pkg::*;

  localparam int QDEPTH = 3;

  mode_t      mode, mode_next;
  logic [8:0] oct_val, oct_val_next;
  logic [1:0] dig_cnt, dig_cnt_next;

  res_t       queue [QDEPTH];
  logic [1:0] rd_ptr, wr_ptr, wr_ptr1;
  logic [1:0] count, count_next;

  logic       in_acc, out_acc;
  logic [1:0] n_res;
  res_t       res0, res1;
  logic       is_oct;
  logic [2:0] digit;
  logic [8:0] oct_grow;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = count > 2'd1;

  assign is_oct   = ch[7:3] == OCT_PREFIX;
  assign digit    = ch[2:0];
  assign oct_grow = {oct_val[5:0], digit};

  // Decode one character into up to two words and the next mode
  always_comb begin
    mode_next    = mode;
    oct_val_next = oct_val;
    dig_cnt_next = dig_cnt;
    n_res        = 2'd0;
    res0         = '{byte_out: ch, eos: is_last, status: ST_OK};
    res1         = '{byte_out: ch, eos: is_last, status: ST_OK};
    case (mode)
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        n_res     = 2'd1;
        if (ch == CH_N) begin
          res0.byte_out = CH_NEWLINE;
        end else if (ch == CH_T) begin
          res0.byte_out = CH_TAB;
        end else if (ch == CH_BACKSLASH || ch == CH_QUOTE) begin
          res0.byte_out = ch;
        end else if (is_oct) begin
          if (is_last) begin
            res0 = oct_word({6'd0, digit}, 1'b1);
          end else begin
            n_res        = 2'd0;
            mode_next    = MODE_OCTAL;
            oct_val_next = {6'd0, digit};
            dig_cnt_next = 2'd1;
          end
        end else begin
          res0.status = ST_UNKNOWN;
        end
      end
      MODE_OCTAL: begin
        if (is_oct) begin
          if (dig_cnt == OCT_LAST_CNT || is_last) begin
            n_res        = 2'd1;
            res0         = oct_word(oct_grow, is_last);
            mode_next    = MODE_NORMAL;
            oct_val_next = '0;
            dig_cnt_next = '0;
          end else begin
            oct_val_next = oct_grow;
            dig_cnt_next = dig_cnt + 2'd1;
          end
        end else begin
          // flush the pending value, then treat ch as a normal character
          res0         = oct_word(oct_val, 1'b0);
          oct_val_next = '0;
          dig_cnt_next = '0;
          mode_next    = MODE_NORMAL;
          n_res        = 2'd2;
          if (ch == CH_BACKSLASH) begin
            if (is_last) begin
              res1 = '{byte_out: CH_NUL, eos: 1'b1, status: ST_UNKNOWN};
            end else begin
              n_res     = 2'd1;
              mode_next = MODE_ESCAPE;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        n_res     = 2'd1;
        if (ch == CH_BACKSLASH) begin
          if (is_last) begin
            res0 = '{byte_out: CH_NUL, eos: 1'b1, status: ST_UNKNOWN};
          end else begin
            n_res     = 2'd0;
            mode_next = MODE_ESCAPE;
          end
        end
      end
    endcase
    // end of literal: start the next one clean
    if (is_last) begin
      mode_next    = MODE_NORMAL;
      oct_val_next = '0;
      dig_cnt_next = '0;
    end
  end

  // Advance decoder state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      oct_val <= '0;
      dig_cnt <= '0;
    end else if (in_acc) begin
      mode    <= mode_next;
      oct_val <= oct_val_next;
      dig_cnt <= dig_cnt_next;
    end
  end

  // Result queue pointers and fill count
  assign wr_ptr1    = (wr_ptr == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
  assign count_next = count + (in_acc ? n_res : 2'd0) - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (out_acc) begin
        rd_ptr <= (rd_ptr == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      if (in_acc) begin
        case (n_res)
          2'd1:    wr_ptr <= wr_ptr1;
          2'd2:    wr_ptr <= (wr_ptr1 == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr1 + 2'd1;
          default: wr_ptr <= wr_ptr;
        endcase
      end
    end
  end

  // Write decoded words into the queue
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      queue[wr_ptr1] <= res1;
    end
  end

  // Drive the queue head
  assign out_valid     = count != 2'd0;
  assign byte_out      = queue[rd_ptr].byte_out;
  assign end_of_string = queue[rd_ptr].eos;
  assign status        = queue[rd_ptr].status;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QDEPTH))
    else $error("result queue over capacity");

  a_idle_state_clean: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_OCTAL |-> (oct_val == 9'd0 && dig_cnt == 2'd0))
    else $error("octal state left over outside octal mode");

  a_octal_digits: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_OCTAL |-> (dig_cnt == 2'd1 || dig_cnt == 2'd2))
    else $error("bad octal digit count");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_last |=> mode == MODE_NORMAL)
    else $error("mode not normal after end of literal");

  a_stall_room: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> count <= 2'(QDEPTH))
    else $error("accepted character overran the queue");

endmodule
